// ===== src/rk4s_pkg.sv =====
// ----------------------------------------------------------------------------
// rk4s_pkg : shared types, constants and microcode for the RK4 step unit
// Fixed-point formats, saturating helpers and the slope-evaluation program
// that drives the shared multiply / add datapath.
// ----------------------------------------------------------------------------
package rk4s_pkg;

  // Widths and formats
  localparam int DATA_W        = 64;
  localparam int FRACTION_BITS = 32;
  localparam int MAX_STEPS     = 1024;
  localparam int CNT_W         = 11;
  localparam int H_W           = 33;
  localparam int ADDR_W        = 5;
  localparam int PROD_W        = 2 * DATA_W;

  // Reset values of the configuration registers
  localparam logic [H_W-1:0]           STEP_H_RST      = 33'd429496730;
  localparam logic [CNT_W-1:0]         STEPS_TOTAL_RST = 11'd10;
  localparam logic signed [DATA_W-1:0] INITIAL_Y_RST   = 64'sd1431655765;

  // Saturation limits
  localparam logic signed [DATA_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  // Divide by six: floor(n/6) = (n * ceil(2^66/6)) >> 66 for any 64-bit n
  localparam logic [DATA_W-1:0] DIV6_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam int                DIV6_SHIFT = 66;
  localparam logic [DATA_W-1:0] DIV6_BIAS  = 64'd3;

  // Rounding offsets preloaded into the product accumulator
  localparam logic [PROD_W-1:0] RND_FULL = 128'd1 << (FRACTION_BITS - 1);
  localparam logic [PROD_W-1:0] RND_HALF = 128'd1 << FRACTION_BITS;

  // Register map, index = paddr[4:3]
  typedef enum logic [1:0] {
    REG_STEP_H      = 2'd0,
    REG_STEPS_TOTAL = 2'd1,
    REG_INITIAL_Y   = 2'd2
  } reg_idx_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,  // saturating add
    OP_MULI      = 3'd1,  // product, no scaling
    OP_MULF      = 3'd2,  // product >> FRACTION_BITS, rounded
    OP_MULF_HALF = 3'd3,  // product >> FRACTION_BITS+1, rounded
    OP_DIV6      = 3'd4   // divide by six, rounded
  } op_t;

  // Operand sources
  typedef enum logic [3:0] {
    SRC_X         = 4'd0,
    SRC_Y         = 4'd1,
    SRC_H         = 4'd2,
    SRC_H_HALF    = 4'd3,
    SRC_XM        = 4'd4,
    SRC_XE        = 4'd5,
    SRC_XX        = 4'd6,
    SRC_YA        = 4'd7,
    SRC_T         = 4'd8,
    SRC_K         = 4'd9,
    SRC_SUM       = 4'd10,
    SRC_ZERO      = 4'd11,
    SRC_TWO       = 4'd12,
    SRC_FIFTY     = 4'd13,
    SRC_NEG_FIFTY = 4'd14
  } src_t;

  // Write-back destinations
  typedef enum logic [3:0] {
    DST_X   = 4'd0,
    DST_Y   = 4'd1,
    DST_XM  = 4'd2,
    DST_XE  = 4'd3,
    DST_XX  = 4'd4,
    DST_YA  = 4'd5,
    DST_T   = 4'd6,
    DST_K   = 4'd7,
    DST_SUM = 4'd8
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t src_a;
    src_t src_b;
    dst_t dst;
    logic last;
  } uop_t;

  localparam int UCODE_LEN = 42;
  localparam int PC_W      = $clog2(UCODE_LEN);

  function automatic uop_t mk(input op_t op, input src_t a, input src_t b, input dst_t d,
                              input logic last);
    uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    u.last  = last;
    return u;
  endfunction

  // One RK4 step: midpoints, four slopes, weighted sum, y and x update
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // x at the midpoint and at the end of the step
      6'd0:  u = mk(OP_ADD,       SRC_X,   SRC_H_HALF,    DST_XM,  1'b0);
      6'd1:  u = mk(OP_ADD,       SRC_X,   SRC_H,         DST_XE,  1'b0);
      // k1 = f(x, y)
      6'd2:  u = mk(OP_MULI,      SRC_Y,   SRC_NEG_FIFTY, DST_T,   1'b0);
      6'd3:  u = mk(OP_MULF,      SRC_X,   SRC_X,         DST_XX,  1'b0);
      6'd4:  u = mk(OP_MULI,      SRC_XX,  SRC_FIFTY,     DST_XX,  1'b0);
      6'd5:  u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_T,   1'b0);
      6'd6:  u = mk(OP_MULI,      SRC_X,   SRC_TWO,       DST_XX,  1'b0);
      6'd7:  u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_K,   1'b0);
      6'd8:  u = mk(OP_ADD,       SRC_K,   SRC_ZERO,      DST_SUM, 1'b0);
      // k2 = f(xm, y + h*k1/2)
      6'd9:  u = mk(OP_MULF_HALF, SRC_K,   SRC_H,         DST_T,   1'b0);
      6'd10: u = mk(OP_ADD,       SRC_Y,   SRC_T,         DST_YA,  1'b0);
      6'd11: u = mk(OP_MULI,      SRC_YA,  SRC_NEG_FIFTY, DST_T,   1'b0);
      6'd12: u = mk(OP_MULF,      SRC_XM,  SRC_XM,        DST_XX,  1'b0);
      6'd13: u = mk(OP_MULI,      SRC_XX,  SRC_FIFTY,     DST_XX,  1'b0);
      6'd14: u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_T,   1'b0);
      6'd15: u = mk(OP_MULI,      SRC_XM,  SRC_TWO,       DST_XX,  1'b0);
      6'd16: u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_K,   1'b0);
      6'd17: u = mk(OP_MULI,      SRC_K,   SRC_TWO,       DST_T,   1'b0);
      6'd18: u = mk(OP_ADD,       SRC_SUM, SRC_T,         DST_SUM, 1'b0);
      // k3 = f(xm, y + h*k2/2)
      6'd19: u = mk(OP_MULF_HALF, SRC_K,   SRC_H,         DST_T,   1'b0);
      6'd20: u = mk(OP_ADD,       SRC_Y,   SRC_T,         DST_YA,  1'b0);
      6'd21: u = mk(OP_MULI,      SRC_YA,  SRC_NEG_FIFTY, DST_T,   1'b0);
      6'd22: u = mk(OP_MULF,      SRC_XM,  SRC_XM,        DST_XX,  1'b0);
      6'd23: u = mk(OP_MULI,      SRC_XX,  SRC_FIFTY,     DST_XX,  1'b0);
      6'd24: u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_T,   1'b0);
      6'd25: u = mk(OP_MULI,      SRC_XM,  SRC_TWO,       DST_XX,  1'b0);
      6'd26: u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_K,   1'b0);
      6'd27: u = mk(OP_MULI,      SRC_K,   SRC_TWO,       DST_T,   1'b0);
      6'd28: u = mk(OP_ADD,       SRC_SUM, SRC_T,         DST_SUM, 1'b0);
      // k4 = f(x + h, y + h*k3)
      6'd29: u = mk(OP_MULF,      SRC_K,   SRC_H,         DST_T,   1'b0);
      6'd30: u = mk(OP_ADD,       SRC_Y,   SRC_T,         DST_YA,  1'b0);
      6'd31: u = mk(OP_MULI,      SRC_YA,  SRC_NEG_FIFTY, DST_T,   1'b0);
      6'd32: u = mk(OP_MULF,      SRC_XE,  SRC_XE,        DST_XX,  1'b0);
      6'd33: u = mk(OP_MULI,      SRC_XX,  SRC_FIFTY,     DST_XX,  1'b0);
      6'd34: u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_T,   1'b0);
      6'd35: u = mk(OP_MULI,      SRC_XE,  SRC_TWO,       DST_XX,  1'b0);
      6'd36: u = mk(OP_ADD,       SRC_T,   SRC_XX,        DST_K,   1'b0);
      6'd37: u = mk(OP_ADD,       SRC_SUM, SRC_K,         DST_SUM, 1'b0);
      // y += round(h*sum)/6, x += h
      6'd38: u = mk(OP_MULF,      SRC_SUM, SRC_H,         DST_T,   1'b0);
      6'd39: u = mk(OP_DIV6,      SRC_T,   SRC_ZERO,      DST_T,   1'b0);
      6'd40: u = mk(OP_ADD,       SRC_Y,   SRC_T,         DST_Y,   1'b0);
      6'd41: u = mk(OP_ADD,       SRC_XE,  SRC_ZERO,      DST_X,   1'b1);
      default: u = mk(OP_ADD,     SRC_ZERO, SRC_ZERO,     DST_T,   1'b1);
    endcase
    return u;
  endfunction

  // Two's complement add, clamped to the signed 64-bit range
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] r;
    s = a + b;
    if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1])) begin
      r = a[DATA_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Sign and magnitude back to a saturated signed word
  function automatic logic signed [DATA_W-1:0] sat_pack(input logic neg,
                                                        input logic [PROD_W-1:0] mag);
    logic                     over_pos;
    logic                     over_neg;
    logic signed [DATA_W-1:0] r;
    over_pos = (mag[PROD_W-1:DATA_W-1] != '0);
    over_neg = (mag[PROD_W-1:DATA_W] != '0) ||
               (mag[DATA_W-1] && (mag[DATA_W-2:0] != '0));
    if (neg) begin
      r = over_neg ? SAT_MIN : $signed(DATA_W'(0) - mag[DATA_W-1:0]);
    end else begin
      r = over_pos ? SAT_MAX : $signed(mag[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== src/rk4_ode_integrator_step_unit.sv =====
// ----------------------------------------------------------------------------
// rk4_ode_integrator_step_unit : one RK4 step of y' = -50y + 50x^2 + 2x
// Signed Q32.32 integrator with saturating arithmetic, built around one
// shared 32x32 multiplier and one saturating adder under a microcode sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): each word carries in_restart. A word
//   with restart set reloads x = 0, y = initial_y and the step count, then
//   steps. Without restart it advances from the stored point; once the run of
//   steps_total steps is complete such a word is consumed with no result.
//   Result channel (out_valid / out_stall): step_index, x_value, y_value and
//   done_res of the step just taken, held in an output register.
//   Configuration: APB-style port, 64-bit data, step_h at 0x00, steps_total
//   at 0x08, initial_y at 0x10; write only while the unit is idle.
//   Sequencing: one step runs 42 microcode operations; an add completes in
//   ST_RUN, a product goes through ST_RUN, ST_MUL (upper-half slices of the
//   second operand skipped when that half is zero), ST_ACC and ST_PACK.
//   Then ST_EMIT waits for the output register and returns to ST_IDLE.
//   The unit holds in_stall high outside ST_IDLE, so no new word goes in
//   until the step is emitted; throughput is set by the shared multiplier.
//   A new word is accepted while the previous result still waits; if the
//   receiver stalls, the next result waits in the unit until the register
//   frees up. Reset (synchronous, rst_n low) loads the default registers,
//   x = 0, y = one third and an empty output.
// ----------------------------------------------------------------------------
module rk4_ode_integrator_step_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rk4s_pkg::CNT_W-1:0]          out_step_index,
  output logic signed [rk4s_pkg::DATA_W-1:0]  out_x_value,
  output logic signed [rk4s_pkg::DATA_W-1:0]  out_y_value,
  output logic                                out_done_res,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rk4s_pkg::ADDR_W-1:0]         paddr,
  input  logic [rk4s_pkg::DATA_W-1:0]         pwdata,
  output logic [rk4s_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  import rk4s_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RUN  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_PACK = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  // Configuration registers
  logic [H_W-1:0]           step_h_r, step_h_nxt;
  logic [CNT_W-1:0]         steps_total_r, steps_total_nxt;
  logic signed [DATA_W-1:0] initial_y_r, initial_y_nxt;

  // Integrator state and scratch registers
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] y_r, y_nxt;
  logic signed [DATA_W-1:0] xm_r, xm_nxt;
  logic signed [DATA_W-1:0] xe_r, xe_nxt;
  logic signed [DATA_W-1:0] xx_r, xx_nxt;
  logic signed [DATA_W-1:0] ya_r, ya_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic signed [DATA_W-1:0] k_r, k_nxt;
  logic signed [DATA_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]         steps_done_r, steps_done_nxt;

  // Sequencer
  state_t                   state_r, state_nxt;
  logic [PC_W-1:0]          pc_r, pc_nxt;

  // Multiplier unit
  logic [DATA_W-1:0]        a_mag_r, a_mag_nxt;
  logic [DATA_W-1:0]        b_mag_r, b_mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [PROD_W-1:0]        acc_r, acc_nxt;
  logic [1:0]               mcnt_r, mcnt_nxt;
  logic [DATA_W-1:0]        pp_r, pp_nxt;
  logic [1:0]               pp_pos_r, pp_pos_nxt;
  logic                     pp_vld_r, pp_vld_nxt;
  op_t                      op_r, op_nxt;
  dst_t                     dst_r, dst_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]         out_step_index_r, out_step_index_nxt;
  logic signed [DATA_W-1:0] out_x_value_r, out_x_value_nxt;
  logic signed [DATA_W-1:0] out_y_value_r, out_y_value_nxt;
  logic                     out_done_res_r, out_done_res_nxt;

  // Combinational helpers
  uop_t                     uop;
  logic signed [DATA_W-1:0] opa, opb;
  logic signed [DATA_W-1:0] add_res;
  logic [DATA_W-1:0]        a_abs, b_abs;
  logic [DATA_W/2-1:0]      a_part, b_part;
  logic [DATA_W-1:0]        pp_full;
  logic [PROD_W-1:0]        pp_shift;
  logic [PROD_W-1:0]        scaled;
  logic signed [DATA_W-1:0] pack_res;
  logic                     mul_last;
  logic                     wb_en;
  dst_t                     wb_dst;
  logic signed [DATA_W-1:0] wb_data;
  logic [CNT_W-1:0]         total_eff;
  logic [CNT_W-1:0]         steps_inc;
  logic                     in_acc;
  logic                     out_free;
  logic                     cfg_wr;

  // Operand select
  function automatic logic signed [DATA_W-1:0] src_sel(input src_t s);
    logic signed [DATA_W-1:0] v;
    case (s)
      SRC_X:         v = x_r;
      SRC_Y:         v = y_r;
      SRC_H:         v = $signed({{(DATA_W-H_W){1'b0}}, step_h_r});
      SRC_H_HALF:    v = $signed({{(DATA_W-H_W+1){1'b0}}, step_h_r[H_W-1:1]});
      SRC_XM:        v = xm_r;
      SRC_XE:        v = xe_r;
      SRC_XX:        v = xx_r;
      SRC_YA:        v = ya_r;
      SRC_T:         v = t_r;
      SRC_K:         v = k_r;
      SRC_SUM:       v = sum_r;
      SRC_TWO:       v = 64'sd2;
      SRC_FIFTY:     v = 64'sd50;
      SRC_NEG_FIFTY: v = -64'sd50;
      default:       v = '0;
    endcase
    return v;
  endfunction

  // Microcode fetch and operand read
  always_comb begin
    uop     = ucode(pc_r);
    opa     = src_sel(uop.src_a);
    opb     = src_sel(uop.src_b);
    add_res = sat_add(opa, opb);
    a_abs   = opa[DATA_W-1] ? ($unsigned(~opa) + DATA_W'(1)) : $unsigned(opa);
    b_abs   = opb[DATA_W-1] ? ($unsigned(~opb) + DATA_W'(1)) : $unsigned(opb);
  end

  // Partial products: a0*b0, a1*b0, a0*b1, a1*b1
  always_comb begin
    a_part   = mcnt_r[0] ? a_mag_r[DATA_W-1:DATA_W/2] : a_mag_r[DATA_W/2-1:0];
    b_part   = mcnt_r[1] ? b_mag_r[DATA_W-1:DATA_W/2] : b_mag_r[DATA_W/2-1:0];
    pp_full  = a_part * b_part;
    mul_last = (mcnt_r == 2'd3) ||
               ((mcnt_r == 2'd1) && (b_mag_r[DATA_W-1:DATA_W/2] == '0));
    case (pp_pos_r)
      2'd0:       pp_shift = {{DATA_W{1'b0}}, pp_r};
      2'd1, 2'd2: pp_shift = {{(DATA_W/2){1'b0}}, pp_r, {(DATA_W/2){1'b0}}};
      default:    pp_shift = {pp_r, {DATA_W{1'b0}}};
    endcase
  end

  // Scale and saturate the finished product
  always_comb begin
    case (op_r)
      OP_MULF:      scaled = acc_r >> FRACTION_BITS;
      OP_MULF_HALF: scaled = acc_r >> (FRACTION_BITS + 1);
      OP_DIV6:      scaled = acc_r >> DIV6_SHIFT;
      default:      scaled = acc_r;
    endcase
    pack_res = sat_pack(neg_r, scaled);
  end

  // Step count limits
  always_comb begin
    if (steps_total_r == '0) begin
      total_eff = CNT_W'(1);
    end else if (steps_total_r > CNT_W'(MAX_STEPS)) begin
      total_eff = CNT_W'(MAX_STEPS);
    end else begin
      total_eff = steps_total_r;
    end
    steps_inc = steps_done_r + CNT_W'(1);
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite;

  // Sequencer and datapath control
  always_comb begin
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    a_mag_nxt  = a_mag_r;
    b_mag_nxt  = b_mag_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    mcnt_nxt   = mcnt_r;
    pp_nxt     = pp_r;
    pp_pos_nxt = pp_pos_r;
    pp_vld_nxt = pp_vld_r;
    op_nxt     = op_r;
    dst_nxt    = dst_r;
    wb_en      = 1'b0;
    wb_dst     = dst_r;
    wb_data    = pack_res;

    steps_done_nxt     = steps_done_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_step_index_nxt = out_step_index_r;
    out_x_value_nxt    = out_x_value_r;
    out_y_value_nxt    = out_y_value_r;
    out_done_res_nxt   = out_done_res_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_restart) begin
            steps_done_nxt = '0;
            state_nxt      = ST_RUN;
            pc_nxt         = '0;
          end else if (steps_done_r < total_eff) begin
            state_nxt = ST_RUN;
            pc_nxt    = '0;
          end
        end
      end
      ST_RUN: begin
        if (uop.op == OP_ADD) begin
          wb_en   = 1'b1;
          wb_dst  = uop.dst;
          wb_data = add_res;
          if (uop.last) begin
            state_nxt = ST_EMIT;
          end else begin
            pc_nxt = pc_r + PC_W'(1);
          end
        end else begin
          // load operands, preload rounding offset
          a_mag_nxt  = a_abs + ((uop.op == OP_DIV6) ? DIV6_BIAS : '0);
          b_mag_nxt  = (uop.op == OP_DIV6) ? DIV6_MAGIC : b_abs;
          neg_nxt    = opa[DATA_W-1] ^ opb[DATA_W-1];
          acc_nxt    = (uop.op == OP_MULF) ? RND_FULL :
                       (uop.op == OP_MULF_HALF) ? RND_HALF : '0;
          mcnt_nxt   = '0;
          pp_vld_nxt = 1'b0;
          op_nxt     = uop.op;
          dst_nxt    = uop.dst;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        // multiply one slice, accumulate the previous one
        pp_nxt     = pp_full;
        pp_pos_nxt = mcnt_r;
        pp_vld_nxt = 1'b1;
        if (pp_vld_r) begin
          acc_nxt = acc_r + pp_shift;
        end
        mcnt_nxt = mcnt_r + 2'd1;
        if (mul_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_nxt    = acc_r + pp_shift;
        pp_vld_nxt = 1'b0;
        state_nxt  = ST_PACK;
      end
      ST_PACK: begin
        wb_en     = 1'b1;
        pc_nxt    = pc_r + PC_W'(1);
        state_nxt = ST_RUN;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_step_index_nxt = steps_inc;
          out_x_value_nxt    = x_r;
          out_y_value_nxt    = y_r;
          out_done_res_nxt   = (steps_inc >= total_eff);
          steps_done_nxt     = steps_inc;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Register write-back
  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    xm_nxt  = xm_r;
    xe_nxt  = xe_r;
    xx_nxt  = xx_r;
    ya_nxt  = ya_r;
    t_nxt   = t_r;
    k_nxt   = k_r;
    sum_nxt = sum_r;
    if (in_acc && in_restart) begin
      x_nxt = '0;
      y_nxt = initial_y_r;
    end
    if (wb_en) begin
      case (wb_dst)
        DST_X:   x_nxt   = wb_data;
        DST_Y:   y_nxt   = wb_data;
        DST_XM:  xm_nxt  = wb_data;
        DST_XE:  xe_nxt  = wb_data;
        DST_XX:  xx_nxt  = wb_data;
        DST_YA:  ya_nxt  = wb_data;
        DST_T:   t_nxt   = wb_data;
        DST_K:   k_nxt   = wb_data;
        DST_SUM: sum_nxt = wb_data;
        default: t_nxt   = t_r;
      endcase
    end
  end

  // Configuration write and read
  always_comb begin
    step_h_nxt      = step_h_r;
    steps_total_nxt = steps_total_r;
    initial_y_nxt   = initial_y_r;
    if (cfg_wr) begin
      case (reg_idx_t'(paddr[ADDR_W-1:3]))
        REG_STEP_H:      step_h_nxt      = pwdata[H_W-1:0];
        REG_STEPS_TOTAL: steps_total_nxt = pwdata[CNT_W-1:0];
        REG_INITIAL_Y:   initial_y_nxt   = $signed(pwdata);
        default:         step_h_nxt      = step_h_r;
      endcase
    end
    case (reg_idx_t'(paddr[ADDR_W-1:3]))
      REG_STEP_H:      prdata = {{(DATA_W-H_W){1'b0}}, step_h_r};
      REG_STEPS_TOTAL: prdata = {{(DATA_W-CNT_W){1'b0}}, steps_total_r};
      REG_INITIAL_Y:   prdata = $unsigned(initial_y_r);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pc_r          <= '0;
      pp_vld_r      <= 1'b0;
      mcnt_r        <= '0;
      out_valid_r   <= 1'b0;
      steps_done_r  <= '0;
      x_r           <= '0;
      y_r           <= INITIAL_Y_RST;
      step_h_r      <= STEP_H_RST;
      steps_total_r <= STEPS_TOTAL_RST;
      initial_y_r   <= INITIAL_Y_RST;
    end else begin
      state_r       <= state_nxt;
      pc_r          <= pc_nxt;
      pp_vld_r      <= pp_vld_nxt;
      mcnt_r        <= mcnt_nxt;
      out_valid_r   <= out_valid_nxt;
      steps_done_r  <= steps_done_nxt;
      x_r           <= x_nxt;
      y_r           <= y_nxt;
      step_h_r      <= step_h_nxt;
      steps_total_r <= steps_total_nxt;
      initial_y_r   <= initial_y_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    xm_r             <= xm_nxt;
    xe_r             <= xe_nxt;
    xx_r             <= xx_nxt;
    ya_r             <= ya_nxt;
    t_r              <= t_nxt;
    k_r              <= k_nxt;
    sum_r            <= sum_nxt;
    a_mag_r          <= a_mag_nxt;
    b_mag_r          <= b_mag_nxt;
    neg_r            <= neg_nxt;
    acc_r            <= acc_nxt;
    pp_r             <= pp_nxt;
    pp_pos_r         <= pp_pos_nxt;
    op_r             <= op_nxt;
    dst_r            <= dst_nxt;
    out_step_index_r <= out_step_index_nxt;
    out_x_value_r    <= out_x_value_nxt;
    out_y_value_r    <= out_y_value_nxt;
    out_done_res_r   <= out_done_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_step_index = out_step_index_r;
  assign out_x_value    = out_x_value_r;
  assign out_y_value    = out_y_value_r;
  assign out_done_res   = out_done_res_r;

  // Checks
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (pc_r < PC_W'(UCODE_LEN)))
    else $error("microcode pc out of range");

  a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> ($past(state_r) == ST_MUL))
    else $error("accumulate stage without multiply");

  a_pack_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PACK) |-> !pp_vld_r)
    else $error("partial product left when packing");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_done_r <= CNT_W'(MAX_STEPS))
    else $error("step count beyond limit");

  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && out_free) |=> (out_valid && (out_step_index == steps_done_r)))
    else $error("emitted step index does not match count");

endmodule
